>>> rtl/binary_buddy_allocator_assert.svh
// Assertion macros for the buddy allocator.
`ifndef BINARY_BUDDY_ALLOCATOR_ASSERT_SVH
`define BINARY_BUDDY_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define BBA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define BBA_ASSERT(lbl, cond, msg)
`define BBA_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/bba_pkg.sv
// Shared codes of the buddy allocator.
package bba_pkg;
	localparam logic       REQ_ALLOC      = 1'b0;
	localparam logic       REQ_FREE       = 1'b1;
	localparam logic [1:0] STAT_ALLOCATED = 2'd0;
	localparam logic [1:0] STAT_NOMEM     = 2'd1;
	localparam logic [1:0] STAT_FREED     = 2'd2;
	localparam logic [1:0] STAT_IGNORED   = 2'd3;
endpackage

>>> rtl/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
	parameter int W = 1,
	parameter int D = 4096
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> rtl/binary_buddy_allocator.sv
// Buddy allocator top level: request sequencer over split, parity and free-list memories.
// After reset the block clears every entry of its split and parity memories, one entry a
// cycle, and takes no item meanwhile. It then handles one item at a time. An oversize
// allocate or an ignored free goes straight to its result; an allocate first looks for a
// free level, gives no-memory if none holds a block, else pops a block and splits it one
// level at a time down to the level asked for. A free searches the split memory level by
// level (up to MAX_LOG2-MIN_LOG2 levels), then frees the block found at once when it is
// the whole region, else flips its parity bit and merges with its buddy level by level
// while the buddy is free. Each merge step reads the parity memory and then writes it
// back. A result is held in an output register, so the next item is taken while it
// waits; a second result waits until that register drains.
module binary_buddy_allocator import bba_pkg::*; #(
	parameter int MAX_LOG2 = 16,
	parameter int MIN_LOG2 = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [47:0] base_address,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [31:0] request_size,
	input  logic [47:0] address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [47:0] block_address,
	output logic [1:0]  status,
	output logic [3:0]  block_level
);
	localparam int TOPL   = MAX_LOG2 - MIN_LOG2;
	localparam int NLEV   = TOPL + 1;
	localparam int UW     = TOPL;
	localparam int NUNITS = 1 << TOPL;
	localparam int LW     = $clog2(NLEV);

	localparam logic [3:0] S_CLR    = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_AFIND  = 4'd2;
	localparam logic [3:0] S_APOP   = 4'd3;
	localparam logic [3:0] S_APOP2  = 4'd4;
	localparam logic [3:0] S_APUSH2 = 4'd5;
	localparam logic [3:0] S_FSRCH  = 4'd6;
	localparam logic [3:0] S_FSRCH2 = 4'd7;
	localparam logic [3:0] S_FALIGN = 4'd8;
	localparam logic [3:0] S_FFLIP  = 4'd9;
	localparam logic [3:0] S_FFLIP2 = 4'd10;
	localparam logic [3:0] S_FREM   = 4'd11;
	localparam logic [3:0] S_FREM2  = 4'd12;
	localparam logic [3:0] S_FEND   = 4'd13;
	localparam logic [3:0] S_DONE   = 4'd14;

	localparam logic [LW-1:0] TOPL_L = LW'(TOPL);

	function automatic logic [UW:0] node_of(logic [UW-1:0] u, logic [LW-1:0] l);
		node_of = ((UW+1)'(1) << l) - (UW+1)'(1) + ({1'b0, u} >> (TOPL_L - l));
	endfunction

	function automatic logic [UW-1:0] sidx_of(logic [UW-1:0] u, logic [LW-1:0] l);
		logic [UW:0] n;
		n = node_of(u, l);
		sidx_of = n[UW-1:0];
	endfunction

	function automatic logic [UW-1:0] pidx_of(logic [UW-1:0] u, logic [LW-1:0] l);
		logic [UW:0] n;
		n = node_of(u, l) - (UW+1)'(1);
		pidx_of = n[UW:1];
	endfunction

	logic [3:0]    state_q;
	logic [47:0]   base_q;
	logic [UW-1:0] clr_q;
	logic [UW-1:0] head_q [NLEV];
	logic [UW-1:0] tail_q [NLEV];
	logic [NLEV-1:0] lvalid_q;
	logic [LW-1:0] start_q, k_q, lvl_q, i_q, flvl_q;
	logic [UW-1:0] u_q;
	logic          pmulti_q;
	logic [47:0]   res_addr_q;
	logic [1:0]    res_status_q;
	logic [LW-1:0] res_level_q;
	logic          out_valid_q;
	logic [47:0]   out_addr_q;
	logic [1:0]    out_status_q;
	logic [3:0]    out_level_q;

	logic            split_we, split_wdata, split_re, split_rdata;
	logic [UW-1:0]   split_waddr, split_raddr;
	logic            par_we, par_wdata, par_re, par_rdata;
	logic [UW-1:0]   par_waddr, par_raddr;
	logic            nxt_we, nxt_re, prv_we, prv_re;
	logic [UW-1:0]   nxt_waddr, nxt_wdata, nxt_raddr, nxt_rdata;
	logic [UW-1:0]   prv_waddr, prv_wdata, prv_raddr, prv_rdata;

	logic            push_en;
	logic [LW-1:0]   push_lvl;
	logic [UW-1:0]   push_x;
	logic            sfit, jfound;
	logic [LW-1:0]   sstart, jsel;
	logic [47:0]     free_off;
	logic [UW-1:0]   buddy, half, align_mask;
	logic            in_acc;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign free_off  = address - base_q;
	assign buddy     = u_q ^ (UW'(1) << (TOPL_L - lvl_q));
	assign half      = UW'(1) << (TOPL_L - k_q - LW'(1));
	assign align_mask = ~((UW'(1) << (TOPL_L - lvl_q)) - UW'(1));

	always_comb begin
		sfit   = 1'b0;
		sstart = '0;
		for (int i = MAX_LOG2; i >= MIN_LOG2; i--) begin
			if ({32'd0, request_size} <= (64'd1 << i)) begin
				sfit   = 1'b1;
				sstart = LW'(MAX_LOG2 - i);
			end
		end
	end

	always_comb begin
		jfound = 1'b0;
		jsel   = '0;
		for (int j = 0; j < NLEV; j++) begin
			if (LW'(j) <= start_q && lvalid_q[j]) begin
				jfound = 1'b1;
				jsel   = LW'(j);
			end
		end
	end

	always_comb begin
		split_we = 1'b0; split_waddr = '0; split_wdata = 1'b0;
		split_re = 1'b0; split_raddr = '0;
		par_we = 1'b0; par_waddr = '0; par_wdata = 1'b0;
		par_re = 1'b0; par_raddr = '0;
		nxt_we = 1'b0; nxt_waddr = '0; nxt_wdata = '0; nxt_re = 1'b0; nxt_raddr = '0;
		prv_we = 1'b0; prv_waddr = '0; prv_wdata = '0; prv_re = 1'b0; prv_raddr = '0;
		push_en = 1'b0; push_lvl = '0; push_x = '0;
		case (state_q)
			S_CLR: begin
				split_we = 1'b1; split_waddr = clr_q;
				par_we = 1'b1; par_waddr = clr_q;
			end
			S_APOP: begin
				if (head_q[k_q] != tail_q[k_q]) begin
					nxt_re = 1'b1; nxt_raddr = head_q[k_q];
				end
				if (k_q != '0) begin
					par_re = 1'b1; par_raddr = pidx_of(head_q[k_q], k_q);
				end
			end
			S_APOP2: begin
				if (k_q != '0) begin
					par_we = 1'b1; par_waddr = pidx_of(u_q, k_q); par_wdata = ~par_rdata;
				end
				if (k_q != start_q) begin
					split_we = 1'b1; split_waddr = sidx_of(u_q, k_q);
					split_wdata = 1'b1;
					push_en = 1'b1; push_lvl = k_q + LW'(1); push_x = u_q;
				end
			end
			S_APUSH2: begin
				push_en = 1'b1; push_lvl = k_q + LW'(1); push_x = u_q + half;
			end
			S_FSRCH: begin
				split_re = 1'b1; split_raddr = sidx_of(u_q, i_q - LW'(1));
			end
			S_FFLIP: begin
				par_re = 1'b1; par_raddr = pidx_of(u_q, lvl_q);
			end
			S_FFLIP2: begin
				par_we = 1'b1; par_waddr = pidx_of(u_q, lvl_q); par_wdata = ~par_rdata;
			end
			S_FREM: begin
				if (lvl_q != TOPL_L) begin
					split_we = 1'b1; split_waddr = sidx_of(u_q, lvl_q);
				end
				nxt_re = 1'b1; nxt_raddr = buddy;
				prv_re = 1'b1; prv_raddr = buddy;
			end
			S_FREM2: begin
				if (lvalid_q[lvl_q] && head_q[lvl_q] != buddy && tail_q[lvl_q] != buddy) begin
					nxt_we = 1'b1; nxt_waddr = prv_rdata; nxt_wdata = nxt_rdata;
					prv_we = 1'b1; prv_waddr = nxt_rdata; prv_wdata = prv_rdata;
				end
			end
			S_FEND: begin
				if (lvl_q != TOPL_L) begin
					split_we = 1'b1; split_waddr = sidx_of(u_q, lvl_q);
				end
				push_en = 1'b1; push_lvl = lvl_q; push_x = u_q;
			end
			default: begin
			end
		endcase
		if (push_en && lvalid_q[push_lvl]) begin
			nxt_we = 1'b1; nxt_waddr = tail_q[push_lvl]; nxt_wdata = push_x;
			prv_we = 1'b1; prv_waddr = push_x; prv_wdata = tail_q[push_lvl];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			base_q      <= 48'd65536;
			lvalid_q    <= NLEV'(1);
			out_valid_q <= 1'b0;
			for (int l = 0; l < NLEV; l++) begin
				head_q[l] <= '0;
				tail_q[l] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				base_q <= base_address;
			end
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			if (push_en) begin
				tail_q[push_lvl] <= push_x;
				if (!lvalid_q[push_lvl]) begin
					head_q[push_lvl]   <= push_x;
					lvalid_q[push_lvl] <= 1'b1;
				end
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + UW'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						res_addr_q  <= '0;
						res_level_q <= '0;
						if (req_type == REQ_ALLOC) begin
							start_q <= sstart;
							if (sfit) begin
								state_q <= S_AFIND;
							end else begin
								res_status_q <= STAT_NOMEM;
								state_q      <= S_DONE;
							end
						end else if (address == '0 || (free_off >> MAX_LOG2) != '0) begin
							res_status_q <= STAT_IGNORED;
							state_q      <= S_DONE;
						end else begin
							u_q     <= free_off[MAX_LOG2-1:MIN_LOG2];
							i_q     <= TOPL_L;
							state_q <= S_FSRCH;
						end
					end
				end
				S_AFIND: begin
					k_q <= jsel;
					if (jfound) begin
						state_q <= S_APOP;
					end else begin
						res_status_q <= STAT_NOMEM;
						state_q      <= S_DONE;
					end
				end
				S_APOP: begin
					u_q      <= head_q[k_q];
					pmulti_q <= (head_q[k_q] != tail_q[k_q]);
					if (head_q[k_q] == tail_q[k_q]) begin
						lvalid_q[k_q] <= 1'b0;
					end
					state_q <= S_APOP2;
				end
				S_APOP2: begin
					if (pmulti_q) begin
						head_q[k_q] <= nxt_rdata;
					end
					if (k_q == start_q) begin
						res_addr_q   <= base_q + (48'(u_q) << MIN_LOG2);
						res_status_q <= STAT_ALLOCATED;
						res_level_q  <= start_q;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_APUSH2;
					end
				end
				S_APUSH2: begin
					k_q     <= k_q + LW'(1);
					state_q <= S_APOP;
				end
				S_FSRCH: begin
					state_q <= S_FSRCH2;
				end
				S_FSRCH2: begin
					if (split_rdata) begin
						lvl_q   <= i_q;
						state_q <= S_FALIGN;
					end else if (i_q == LW'(1)) begin
						lvl_q   <= '0;
						state_q <= S_FALIGN;
					end else begin
						i_q     <= i_q - LW'(1);
						state_q <= S_FSRCH;
					end
				end
				S_FALIGN: begin
					u_q     <= u_q & align_mask;
					flvl_q  <= lvl_q;
					state_q <= (lvl_q != '0) ? S_FFLIP : S_FEND;
				end
				S_FFLIP: begin
					state_q <= S_FFLIP2;
				end
				S_FFLIP2: begin
					state_q <= par_rdata ? S_FREM : S_FEND;
				end
				S_FREM: begin
					state_q <= S_FREM2;
				end
				S_FREM2: begin
					if (lvalid_q[lvl_q]) begin
						if (head_q[lvl_q] == buddy && tail_q[lvl_q] == buddy) begin
							lvalid_q[lvl_q] <= 1'b0;
						end else if (head_q[lvl_q] == buddy) begin
							head_q[lvl_q] <= nxt_rdata;
						end else if (tail_q[lvl_q] == buddy) begin
							tail_q[lvl_q] <= prv_rdata;
						end
					end
					if (buddy < u_q) begin
						u_q <= buddy;
					end
					lvl_q   <= lvl_q - LW'(1);
					state_q <= (lvl_q != LW'(1)) ? S_FFLIP : S_FEND;
				end
				S_FEND: begin
					res_status_q <= STAT_FREED;
					res_level_q  <= flvl_q;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						out_addr_q   <= res_addr_q;
						out_status_q <= res_status_q;
						out_level_q  <= 4'(res_level_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign block_address = out_addr_q;
	assign status        = out_status_q;
	assign block_level   = out_level_q;

	bba_ram #(.W(1), .D(NUNITS)) u_split (
		.clk(clk), .we(split_we), .waddr(split_waddr), .wdata(split_wdata),
		.re(split_re), .raddr(split_raddr), .rdata(split_rdata)
	);
	bba_ram #(.W(1), .D(NUNITS)) u_parity (
		.clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
		.re(par_re), .raddr(par_raddr), .rdata(par_rdata)
	);
	bba_ram #(.W(UW), .D(NUNITS)) u_next (
		.clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
		.re(nxt_re), .raddr(nxt_raddr), .rdata(nxt_rdata)
	);
	bba_ram #(.W(UW), .D(NUNITS)) u_prev (
		.clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
		.re(prv_re), .raddr(prv_raddr), .rdata(prv_rdata)
	);

`include "binary_buddy_allocator_assert.svh"
	`BBA_ASSERT_IMP(a_out_from_done, $rose(out_valid_q), $past(state_q == S_DONE), "result without completion")
	`BBA_ASSERT_IMP(a_pop_nonempty, state_q == S_APOP, lvalid_q[k_q], "pop from empty level")
	`BBA_ASSERT_IMP(a_grant_in_region, out_valid_q && out_status_q == STAT_ALLOCATED, ((48'(out_addr_q - base_q)) >> MAX_LOG2) == '0, "grant outside region")
	`BBA_ASSERT_IMP(a_fail_zero, out_valid_q && out_status_q != STAT_ALLOCATED, out_addr_q == '0, "address on non-grant")
endmodule

>>> bench/bba_checker.sv
// Checker for the buddy allocator: watches the channels, predicts each result and compares.
module bba_checker import bba_pkg::*; #(
	parameter int MAX_LOG2 = 16,
	parameter int MIN_LOG2 = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [47:0] base_address,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        req_type,
	input  logic [31:0] request_size,
	input  logic [47:0] address,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [47:0] block_address,
	input  logic [1:0]  status,
	input  logic [3:0]  block_level,
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TOPL = MAX_LOG2 - MIN_LOG2;
	localparam int NU = 1 << TOPL;

	typedef struct packed {
		logic [47:0] addr;
		logic [1:0]  st;
		logic [3:0]  lvl;
	} grant_t;

	grant_t      grant_q[$];
	logic [47:0] region_base;
	bit          split_mem[NU];
	bit          par_mem[NU];
	int          head[TOPL+1];
	int          tail[TOPL+1];
	bit          lvalid[TOPL+1];
	int          nxt[NU];
	int          prv[NU];

	assign outstanding = grant_q.size();

	function automatic int node_at(int u, int l);
		return ((1 << l) - 1) + ((u & (NU - 1)) >> (TOPL - l));
	endfunction

	function automatic int pair_at(int u, int l);
		return ((node_at(u, l) - 1) >> 1) & (NU - 1);
	endfunction

	function automatic void push_free(int l, int u);
		int x;
		x = u & (NU - 1);
		if (!lvalid[l]) begin
			head[l] = x;
			tail[l] = x;
			lvalid[l] = 1;
		end else begin
			nxt[tail[l] & (NU - 1)] = x;
			prv[x] = tail[l];
			tail[l] = x;
		end
	endfunction

	function automatic int pop_free(int l);
		int h;
		h = head[l];
		if (h == tail[l])
			lvalid[l] = 0;
		else
			head[l] = nxt[h & (NU - 1)];
		return h & (NU - 1);
	endfunction

	function automatic void unlink_free(int l, int u);
		int x;
		x = u & (NU - 1);
		if (!lvalid[l])
			return;
		if (head[l] == x && tail[l] == x)
			lvalid[l] = 0;
		else if (head[l] == x)
			head[l] = nxt[x];
		else if (tail[l] == x)
			tail[l] = prv[x];
		else begin
			nxt[prv[x] & (NU - 1)] = nxt[x];
			prv[nxt[x] & (NU - 1)] = prv[x];
		end
	endfunction

	function automatic grant_t grant_block(logic [31:0] size);
		grant_t g;
		int start, j, u;
		logic [47:0] uoff;
		g = '{addr: '0, st: STAT_NOMEM, lvl: '0};
		start = -1;
		for (int i = MIN_LOG2; i <= MAX_LOG2; i++) begin
			if (64'(size) <= (64'd1 << i)) begin
				start = MAX_LOG2 - i;
				break;
			end
		end
		if (start < 0)
			return g;
		j = start;
		while (j >= 0 && !lvalid[j])
			j--;
		if (j < 0)
			return g;
		for (int k = j; k < start; k++) begin
			u = pop_free(k);
			split_mem[node_at(u, k) & (NU - 1)] = 1;
			if (k > 0)
				par_mem[pair_at(u, k)] ^= 1'b1;
			push_free(k + 1, u);
			push_free(k + 1, u + (1 << (TOPL - k - 1)));
		end
		u = pop_free(start);
		if (start > 0)
			par_mem[pair_at(u, start)] ^= 1'b1;
		uoff = 48'(u) << MIN_LOG2;
		g.addr = region_base + uoff;
		g.st = STAT_ALLOCATED;
		g.lvl = 4'(start);
		return g;
	endfunction

	function automatic grant_t release_block(logic [47:0] a);
		grant_t g;
		logic [47:0] off;
		int u, l, buddy;
		g = '{addr: '0, st: STAT_IGNORED, lvl: '0};
		if (a == 0)
			return g;
		off = a - region_base;
		if ((off >> MAX_LOG2) != 0)
			return g;
		u = int'(off >> MIN_LOG2) & (NU - 1);
		l = 0;
		for (int i = TOPL; i > 0; i--) begin
			if (split_mem[node_at(u, i - 1) & (NU - 1)]) begin
				l = i;
				break;
			end
		end
		u &= ~((1 << (TOPL - l)) - 1);
		g.st = STAT_FREED;
		g.lvl = 4'(l);
		if (l > 0)
			par_mem[pair_at(u, l)] ^= 1'b1;
		while (l > 0 && par_mem[pair_at(u, l)] == 0) begin
			if (l < TOPL)
				split_mem[node_at(u, l) & (NU - 1)] = 0;
			buddy = u ^ (1 << (TOPL - l));
			unlink_free(l, buddy);
			if (buddy < u)
				u = buddy;
			l--;
			if (l > 0)
				par_mem[pair_at(u, l)] ^= 1'b1;
		end
		if (l < TOPL)
			split_mem[node_at(u, l) & (NU - 1)] = 0;
		push_free(l, u);
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grant_t got, want;
		if (!arst_n) begin
			region_base = 48'd65536;
			foreach (split_mem[i]) begin
				split_mem[i] = 0;
				par_mem[i] = 0;
				nxt[i] = 0;
				prv[i] = 0;
			end
			foreach (head[i]) begin
				head[i] = 0;
				tail[i] = 0;
				lvalid[i] = 0;
			end
			lvalid[0] = 1;
			grant_q.delete();
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				region_base = base_address;
			if (in_valid && !in_stall) begin
				if (req_type == REQ_ALLOC)
					grant_q.insert(grant_q.size(), grant_block(request_size));
				else
					grant_q.insert(grant_q.size(), release_block(address));
			end
			if (out_valid && !out_stall) begin
				got = '{addr: block_address, st: status, lvl: block_level};
				if (grant_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: addr %h status %0d level %0d",
							got.addr, got.st, got.lvl);
				end else begin
					want = grant_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected addr %h status %0d level %0d, got addr %h status %0d level %0d",
								want.addr, want.st, want.lvl, got.addr, got.st, got.lvl);
					end
				end
			end
		end
	end
endmodule

>>> bench/testbench.sv
// Top of the buddy allocator testbench: stimulus, handshake idling and the verdict.
module testbench;
	import bba_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_LOG2 = 16;
	localparam int MIN_LOG2 = 4;
	localparam int LIMIT = 600000;

	typedef struct {
		logic [47:0] off;
		longint      bytes;
	} held_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [47:0] base_address;
	logic        in_valid;
	logic        in_stall;
	logic        req_type;
	logic [31:0] request_size;
	logic [47:0] address;
	logic        out_valid;
	logic        out_stall;
	logic [47:0] block_address;
	logic [1:0]  status;
	logic [3:0]  block_level;
	int          mismatches;
	int          outstanding;
	int          sent;
	logic [47:0] cur_base;
	held_t       held_q[$];

	binary_buddy_allocator #(.MAX_LOG2(MAX_LOG2), .MIN_LOG2(MIN_LOG2)) dut (.*);

	bba_checker #(.MAX_LOG2(MAX_LOG2), .MIN_LOG2(MIN_LOG2)) checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		for (int c = 0; c < LIMIT; c++)
			@(posedge clk);
		$display("testbench NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall && status == STAT_ALLOCATED)
			held_q.insert(held_q.size(), '{off: block_address - cur_base,
				bytes: longint'(1) << (MAX_LOG2 - block_level)});
	end

	initial begin
		int gap;
		bit pressed;
		pressed = 0;
		out_stall <= 0;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 3);
			if (!pressed && sent >= 200) begin
				pressed = 1;
				out_stall <= 1;
				repeat (400) @(posedge clk);
			end else if (gap > 0 && sent % 150 > 20) begin
				out_stall <= 1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send(logic rt, logic [31:0] size, logic [47:0] a);
		int gap;
		gap = (sent % 120 < 20) ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		req_type <= rt;
		request_size <= size;
		address <= a;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic settle();
		in_valid <= 0;
		do @(posedge clk); while (outstanding != 0);
		repeat (120) @(posedge clk);
	endtask

	task automatic set_base(logic [47:0] b);
		settle();
		cfg_valid <= 1;
		base_address <= b;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		cur_base = b;
	endtask

	task automatic free_held(bit skew);
		held_t h;
		int k;
		logic [47:0] a;
		k = $urandom_range(0, held_q.size() - 1);
		h = held_q[k];
		held_q.delete(k);
		a = cur_base + h.off;
		if (skew)
			a += 48'($urandom_range(0, int'(h.bytes - 1)));
		send(REQ_FREE, 32'($urandom), a);
	endtask

	task automatic random_items(int n);
		int pick;
		logic [31:0] size;
		logic [47:0] junk;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40 && held_q.size() > 0) begin
				free_held(pick < 10);
			end else if (pick < 46) begin
				junk = {16'($urandom), 32'($urandom)};
				case ($urandom_range(0, 2))
					0: send(REQ_FREE, $urandom, '0);
					1: send(REQ_FREE, $urandom, cur_base - 48'($urandom_range(1, 64)));
					default: send(REQ_FREE, $urandom, junk);
				endcase
			end else begin
				case ($urandom_range(0, 9))
					0: size = $urandom;
					1, 2: size = $urandom_range(0, 70000);
					3, 4, 5: size = $urandom_range(0, 2048);
					default: size = $urandom_range(0, 64);
				endcase
				send(REQ_ALLOC, size, {16'($urandom), 32'($urandom)});
			end
		end
	endtask

	initial begin
		logic [47:0] bases[4];
		arst_n = 0;
		cfg_valid = 0;
		base_address = '0;
		in_valid = 0;
		req_type = REQ_ALLOC;
		request_size = '0;
		address = '0;
		sent = 0;
		cur_base = 48'd65536;
		repeat (11) @(posedge clk);
		arst_n <= 1;

		set_base(48'd65536);
		send(REQ_ALLOC, 32'd65536, '0);
		send(REQ_ALLOC, 32'd16, '0);
		settle();
		free_held(0);
		send(REQ_ALLOC, 32'd0, '0);
		send(REQ_ALLOC, 32'd1, '0);
		send(REQ_ALLOC, 32'd16, '0);
		send(REQ_ALLOC, 32'd17, '0);
		send(REQ_ALLOC, 32'd65537, '0);
		send(REQ_ALLOC, 32'hFFFF_FFFF, '0);
		send(REQ_ALLOC, 32'd32768, '0);
		send(REQ_FREE, 32'hFFFF_FFFF, '0);
		send(REQ_FREE, '0, cur_base - 48'd1);
		send(REQ_FREE, '0, cur_base + 48'd65536);
		send(REQ_FREE, '0, 48'hFFFF_FFFF_FFFF);
		settle();
		free_held(1);
		while (held_q.size() > 0)
			free_held(0);

		bases[0] = 48'd0;
		bases[1] = 48'hFFFF_FFFF_FFFF;
		bases[2] = {16'($urandom), 32'($urandom)};
		bases[3] = 48'd65536;
		foreach (bases[p]) begin
			set_base(bases[p]);
			random_items(175);
		end
		send(REQ_FREE, '0, {16'($urandom), 32'($urandom)});
		settle();
		if (mismatches == 0 && outstanding == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule

>>> files.f
+incdir+rtl
rtl/bba_pkg.sv
rtl/bba_ram.sv
rtl/binary_buddy_allocator.sv
bench/bba_checker.sv
bench/testbench.sv
